// File: rtl/efc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int TRIG_STEPS_DEF = 16;

	localparam int ANG_FRAC = 30;
	localparam int VEC_FRAC = 16;
	localparam int PW       = 68;
	localparam int OW       = 34;

	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [17:0] VEC_ONE = 18'sd65536;

	typedef enum logic [1:0] {
		CMD_ROTATE    = 2'd0,
		CMD_TRANSLATE = 2'd1,
		CMD_RESTART   = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		AXIS_FWD   = 2'd0,
		AXIS_RIGHT = 2'd1,
		AXIS_UP    = 2'd2,
		AXIS_NONE  = 2'd3
	} axis_t;

	typedef enum logic [2:0] {
		REG_MOVE_SPEED   = 3'd0,
		REG_ROTATE_SPEED = 3'd1,
		REG_START_X      = 3'd2,
		REG_START_Y      = 3'd3,
		REG_START_Z      = 3'd4,
		REG_START_PITCH  = 3'd5,
		REG_START_YAW    = 3'd6,
		REG_UNUSED       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [33:0] cos_v;
		logic signed [33:0] sin_v;
	} trig_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// add half, then floor shift
	function automatic logic signed [67:0] round_sh(input logic signed [67:0] v, input int n);
		logic signed [67:0] half;
		half = 68'sd1 <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [17:0] clamp_unit(input logic signed [67:0] v);
		logic signed [17:0] r;
		if (v > 68'sd65536) begin
			r = VEC_ONE;
		end else if (v < -68'sd65536) begin
			r = -VEC_ONE;
		end else begin
			r = v[17:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/efc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface efc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic signed [31:0] pitch_delta;
	logic signed [31:0] yaw_delta;
	logic [1:0]  axis;
	logic        positive;
	modport source(output valid, cmd, pitch_delta, yaw_delta, axis, positive, input ready);
	modport sink(input valid, cmd, pitch_delta, yaw_delta, axis, positive, output ready);
endinterface

interface efc_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] pitch_now;
	logic signed [31:0] yaw_now;
	logic signed [17:0] fwd_x;
	logic signed [17:0] fwd_y;
	logic signed [17:0] fwd_z;
	logic signed [17:0] up_x;
	logic signed [17:0] up_y;
	logic signed [17:0] up_z;
	modport source(output valid, pos_x, pos_y, pos_z, pitch_now, yaw_now,
		fwd_x, fwd_y, fwd_z, up_x, up_y, up_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, pitch_now, yaw_now,
		fwd_x, fwd_y, fwd_z, up_x, up_y, up_z, output ready);
endinterface

interface efc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/euler_fly_camera_pose_update.sv
// Euler-angle fly camera pose unit.
// Channels: in_ch (sink) takes one command transaction: rotate, translate or
// restart. out_ch (source) gives one transaction per command: the full pose
// after it (position, pitch, yaw, forward and up vectors). cfg_ch writes the
// speed and start registers; it is always ready. It must be written only while
// idle; the block itself does not enforce this. A translate makes three passes
// of the shared multiplier, then loads the output; a rotate without a vector
// update makes two passes; an unused command or axis goes straight to S_DONE.
// Each sine/cosine run steps through start, (30 - FRAC_BITS + 1) modulo steps,
// the fix-up states A_FIX1 to A_FIX3, TRIG_STEPS CORDIC iterations and done.
// A restart makes two runs and six passes; a rotate with an update adds them.
// One command is processed at a time; in_ch.ready is high only when idle.
// The result sits in an output register; the next command may be accepted
// while it waits, and its own result then holds until out_ch is free.
// Reset: pose at origin, angles zero, forward (1,0,0), up (0,-1,0), move and
// rotate speed 1.0, start registers zero.
`timescale 1ns / 1ps
`default_nettype none
module euler_fly_camera_pose_update #(
	parameter int FRAC_BITS  = efc_pkg::FRAC_BITS_DEF,
	parameter int TRIG_STEPS = efc_pkg::TRIG_STEPS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	efc_in_if.sink     in_ch,
	efc_out_if.source  out_ch,
	efc_cfg_if.sink    cfg_ch
);
	localparam int THR = (1 << FRAC_BITS) / 10000;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_TAKE   = 6'b000100,
		S_TRIG_P = 6'b001000,
		S_TRIG_Y = 6'b010000,
		S_DONE   = 6'b100000
	} st_t;

	typedef enum logic [3:0] {
		OP_PSCALE, OP_YSCALE, OP_MOVE0, OP_MOVE1, OP_MOVE2,
		OP_FX, OP_FZ, OP_UPX, OP_FXX, OP_FZZ, OP_UPZ
	} op_t;

	st_t state_q;
	op_t op_q;

	logic [30:0] move_speed_q, rotate_speed_q;
	logic signed [31:0] start_x_q, start_y_q, start_z_q, start_pitch_q, start_yaw_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] pitch_q, yaw_q;
	logic signed [17:0] fwd_q [3];
	logic signed [17:0] up_q [3];

	logic signed [31:0] pdelta_q, ydelta_q, pu_q;
	logic [1:0] axis_q;
	logic positive_q;
	logic signed [33:0] cp_q, sp_q, cy_q, sy_q;
	logic signed [67:0] acc_q;
	logic trig_start_q;

	logic out_valid_q;
	logic signed [31:0] o_pos_q [3];
	logic signed [31:0] o_pitch_q, o_yaw_q;
	logic signed [17:0] o_fwd_q [3];
	logic signed [17:0] o_up_q [3];

	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic trig_done;
	efc_pkg::trig_t trig_res;
	logic signed [31:0] trig_ang;
	logic signed [17:0] dir [3];

	logic signed [31:0] sc;
	logic signed [32:0] pu_abs, yu_abs;
	logic p_chg, y_chg;
	logic signed [67:0] d, mv;
	logic [1:0] mk;
	logic in_fire;
	logic out_load;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign trig_ang     = (state_q == S_TRIG_P) ? pitch_q : yaw_q;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_comb begin
		case (efc_pkg::axis_t'(axis_q))
			efc_pkg::AXIS_FWD: begin
				dir[0] = fwd_q[0]; dir[1] = fwd_q[1]; dir[2] = fwd_q[2];
			end
			efc_pkg::AXIS_RIGHT: begin
				dir[0] = -fwd_q[2]; dir[1] = 18'sd0; dir[2] = fwd_q[0];
			end
			default: begin
				dir[0] = up_q[0]; dir[1] = up_q[1]; dir[2] = up_q[2];
			end
		endcase
		mk = 2'd0;
		case (op_q)
			OP_MOVE1: mk = 2'd1;
			OP_MOVE2: mk = 2'd2;
			default:  mk = 2'd0;
		endcase
		case (op_q)
			OP_PSCALE: begin ma = 34'(pdelta_q); mb = 34'({1'b0, rotate_speed_q}); end
			OP_YSCALE: begin ma = 34'(ydelta_q); mb = 34'({1'b0, rotate_speed_q}); end
			OP_MOVE0, OP_MOVE1, OP_MOVE2: begin
				ma = 34'({1'b0, move_speed_q}); mb = 34'(dir[mk]);
			end
			OP_FX:  begin ma = cy_q; mb = cp_q; end
			OP_FZ:  begin ma = sy_q; mb = cp_q; end
			OP_UPX: begin ma = 34'(fwd_q[0]); mb = 34'(fwd_q[1]); end
			OP_FXX: begin ma = 34'(fwd_q[0]); mb = 34'(fwd_q[0]); end
			OP_FZZ: begin ma = 34'(fwd_q[2]); mb = 34'(fwd_q[2]); end
			OP_UPZ: begin ma = 34'(fwd_q[1]); mb = 34'(fwd_q[2]); end
			default: begin ma = 34'sd0; mb = 34'sd0; end
		endcase
		sc     = efc_pkg::sat32(efc_pkg::round_sh(prod, FRAC_BITS));
		pu_abs = pu_q[31] ? -33'(pu_q) : 33'(pu_q);
		yu_abs = sc[31] ? -33'(sc) : 33'(sc);
		p_chg  = pu_abs > 33'(THR);
		y_chg  = yu_abs > 33'(THR);
		d      = efc_pkg::round_sh(prod, efc_pkg::VEC_FRAC);
		mv     = positive_q ? 68'(pos_q[mk]) + d : 68'(pos_q[mk]) - d;
	end

	efc_mul u_mul (
		.clk  (clk),
		.a    (ma),
		.b    (mb),
		.p_s1 (prod)
	);

	efc_trig #(
		.FRAC_BITS  (FRAC_BITS),
		.TRIG_STEPS (TRIG_STEPS)
	) u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start_q),
		.angle  (trig_ang),
		.done_q (trig_done),
		.res_q  (trig_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= OP_PSCALE;
			trig_start_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			move_speed_q   <= 31'd65536;
			rotate_speed_q <= 31'd65536;
			start_x_q      <= '0;
			start_y_q      <= '0;
			start_z_q      <= '0;
			start_pitch_q  <= '0;
			start_yaw_q    <= '0;
			pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
			pitch_q  <= '0;
			yaw_q    <= '0;
			fwd_q[0] <= efc_pkg::VEC_ONE; fwd_q[1] <= '0; fwd_q[2] <= '0;
			up_q[0]  <= '0; up_q[1] <= -efc_pkg::VEC_ONE; up_q[2] <= '0;
		end else begin
			trig_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_ch.valid) begin
				case (efc_pkg::reg_idx_t'(cfg_ch.index))
					efc_pkg::REG_MOVE_SPEED:   move_speed_q   <= cfg_ch.data[30:0];
					efc_pkg::REG_ROTATE_SPEED: rotate_speed_q <= cfg_ch.data[30:0];
					efc_pkg::REG_START_X:      start_x_q      <= cfg_ch.data;
					efc_pkg::REG_START_Y:      start_y_q      <= cfg_ch.data;
					efc_pkg::REG_START_Z:      start_z_q      <= cfg_ch.data;
					efc_pkg::REG_START_PITCH:  start_pitch_q  <= cfg_ch.data;
					efc_pkg::REG_START_YAW:    start_yaw_q    <= cfg_ch.data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (efc_pkg::cmd_t'(in_ch.cmd))
							efc_pkg::CMD_ROTATE: begin
								op_q    <= OP_PSCALE;
								state_q <= S_MUL;
							end
							efc_pkg::CMD_TRANSLATE: begin
								op_q    <= OP_MOVE0;
								state_q <= (efc_pkg::axis_t'(in_ch.axis) ==
									efc_pkg::AXIS_NONE) ? S_DONE : S_MUL;
							end
							efc_pkg::CMD_RESTART: begin
								pos_q[0]     <= start_x_q;
								pos_q[1]     <= start_y_q;
								pos_q[2]     <= start_z_q;
								pitch_q      <= start_pitch_q;
								yaw_q        <= start_yaw_q;
								trig_start_q <= 1'b1;
								state_q      <= S_TRIG_P;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: state_q <= S_TAKE;
				S_TAKE: begin
					state_q <= S_MUL;
					case (op_q)
						OP_PSCALE: op_q <= OP_YSCALE;
						OP_YSCALE: begin
							if (p_chg) pitch_q <= efc_pkg::sat32(68'(pitch_q) + 68'(pu_q));
							if (y_chg) yaw_q <= efc_pkg::sat32(68'(yaw_q) + 68'(sc));
							if (p_chg || y_chg) begin
								trig_start_q <= 1'b1;
								state_q      <= S_TRIG_P;
							end else begin
								state_q <= S_DONE;
							end
						end
						OP_MOVE0: begin pos_q[0] <= efc_pkg::sat32(mv); op_q <= OP_MOVE1; end
						OP_MOVE1: begin pos_q[1] <= efc_pkg::sat32(mv); op_q <= OP_MOVE2; end
						OP_MOVE2: begin pos_q[2] <= efc_pkg::sat32(mv); state_q <= S_DONE; end
						OP_FX: begin
							fwd_q[0] <= efc_pkg::clamp_unit(efc_pkg::round_sh(prod,
								2 * efc_pkg::ANG_FRAC - efc_pkg::VEC_FRAC));
							fwd_q[1] <= efc_pkg::clamp_unit(efc_pkg::round_sh(68'(sp_q),
								efc_pkg::ANG_FRAC - efc_pkg::VEC_FRAC));
							op_q <= OP_FZ;
						end
						OP_FZ: begin
							fwd_q[2] <= efc_pkg::clamp_unit(efc_pkg::round_sh(prod,
								2 * efc_pkg::ANG_FRAC - efc_pkg::VEC_FRAC));
							op_q <= OP_UPX;
						end
						OP_UPX: begin
							up_q[0] <= efc_pkg::clamp_unit(d);
							op_q    <= OP_FXX;
						end
						OP_FXX: op_q <= OP_FZZ;
						OP_FZZ: begin
							up_q[1] <= efc_pkg::clamp_unit(efc_pkg::round_sh(-(acc_q + prod),
								efc_pkg::VEC_FRAC));
							op_q <= OP_UPZ;
						end
						OP_UPZ: begin
							up_q[2] <= efc_pkg::clamp_unit(d);
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_TRIG_P: begin
					if (trig_done) begin
						trig_start_q <= 1'b1;
						state_q      <= S_TRIG_Y;
					end
				end
				S_TRIG_Y: begin
					if (trig_done) begin
						op_q    <= OP_FX;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pdelta_q   <= in_ch.pitch_delta;
			ydelta_q   <= in_ch.yaw_delta;
			axis_q     <= in_ch.axis;
			positive_q <= in_ch.positive;
		end
		if (state_q == S_TAKE && op_q == OP_PSCALE) pu_q <= sc;
		if (state_q == S_TAKE && op_q == OP_FXX) acc_q <= prod;
		if (state_q == S_TRIG_P && trig_done) begin
			cp_q <= trig_res.cos_v;
			sp_q <= trig_res.sin_v;
		end
		if (state_q == S_TRIG_Y && trig_done) begin
			cy_q <= trig_res.cos_v;
			sy_q <= trig_res.sin_v;
		end
		if (out_load) begin
			o_pos_q[0] <= pos_q[0];
			o_pos_q[1] <= pos_q[1];
			o_pos_q[2] <= pos_q[2];
			o_pitch_q  <= pitch_q;
			o_yaw_q    <= yaw_q;
			o_fwd_q[0] <= fwd_q[0];
			o_fwd_q[1] <= fwd_q[1];
			o_fwd_q[2] <= fwd_q[2];
			o_up_q[0]  <= up_q[0];
			o_up_q[1]  <= up_q[1];
			o_up_q[2]  <= up_q[2];
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.pos_x     = o_pos_q[0];
	assign out_ch.pos_y     = o_pos_q[1];
	assign out_ch.pos_z     = o_pos_q[2];
	assign out_ch.pitch_now = o_pitch_q;
	assign out_ch.yaw_now   = o_yaw_q;
	assign out_ch.fwd_x     = o_fwd_q[0];
	assign out_ch.fwd_y     = o_fwd_q[1];
	assign out_ch.fwd_z     = o_fwd_q[2];
	assign out_ch.up_x      = o_up_q[0];
	assign out_ch.up_y      = o_up_q[1];
	assign out_ch.up_z      = o_up_q[2];
endmodule
`default_nettype wire

// File: rtl/efc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module efc_mul (
	input  wire                      clk,
	input  wire logic signed [33:0]  a,
	input  wire logic signed [33:0]  b,
	output logic signed [67:0]       p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule
`default_nettype wire

// File: rtl/efc_trig.sv
`timescale 1ns / 1ps
`default_nettype none
module efc_trig #(
	parameter int FRAC_BITS  = efc_pkg::FRAC_BITS_DEF,
	parameter int TRIG_STEPS = efc_pkg::TRIG_STEPS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire logic signed [31:0] angle,
	output logic                    done_q,
	output efc_pkg::trig_t          res_q
);
	localparam int SH = efc_pkg::ANG_FRAC - FRAC_BITS;
	localparam int RW = 33 + SH;
	localparam int IW = $clog2(TRIG_STEPS);

	typedef enum logic [5:0] {
		A_IDLE = 6'b000001,
		A_RED  = 6'b000010,
		A_FIX1 = 6'b000100,
		A_FIX2 = 6'b001000,
		A_FIX3 = 6'b010000,
		A_ROT  = 6'b100000
	} ast_t;

	ast_t state_q;
	logic [RW-1:0] rem_q;
	logic [4:0] k_q;
	logic neg_q, flip_q;
	logic signed [34:0] r_q;
	logic signed [33:0] x_q, y_q;
	logic [IW-1:0] i_q;

	logic signed [32:0] ext;
	logic [31:0] mag;
	logic [RW-1:0] cst;
	logic signed [34:0] r_fix;
	logic signed [34:0] atn;

	always_comb begin
		ext = {angle[31], angle};
		mag = angle[31] ? 32'(-ext) : 32'(ext);
		cst = RW'(efc_pkg::TWO_PI_Q30) << k_q;
		r_fix = 35'(rem_q[32:0]);
		if (neg_q && rem_q[32:0] != 33'd0) begin
			r_fix = 35'(efc_pkg::TWO_PI_Q30) - 35'(rem_q[32:0]);
		end
		atn = 35'(efc_pkg::atan_q30(5'(i_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (start) state_q <= A_RED;
				end
				A_RED: begin
					if (k_q == 5'd0) state_q <= A_FIX1;
				end
				A_FIX1: state_q <= A_FIX2;
				A_FIX2: state_q <= A_FIX3;
				A_FIX3: state_q <= A_ROT;
				A_ROT: begin
					if (i_q == IW'(TRIG_STEPS - 1)) begin
						state_q <= A_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				rem_q <= RW'(mag) << SH;
				neg_q <= angle[31];
				k_q   <= 5'(SH);
			end
			A_RED: begin
				if (rem_q >= cst) rem_q <= rem_q - cst;
				k_q <= k_q - 5'd1;
			end
			A_FIX1: r_q <= r_fix;
			A_FIX2: begin
				if (r_q > $signed(35'(efc_pkg::PI_Q30)))
					r_q <= r_q - 35'(efc_pkg::TWO_PI_Q30);
			end
			A_FIX3: begin
				flip_q <= 1'b0;
				if (r_q > $signed(35'(efc_pkg::HALF_PI_Q30))) begin
					r_q    <= r_q - 35'(efc_pkg::PI_Q30);
					flip_q <= 1'b1;
				end else if (r_q < -$signed(35'(efc_pkg::HALF_PI_Q30))) begin
					r_q    <= r_q + 35'(efc_pkg::PI_Q30);
					flip_q <= 1'b1;
				end
				x_q <= efc_pkg::CORDIC_GAIN_Q30;
				y_q <= 34'sd0;
				i_q <= '0;
			end
			A_ROT: begin
				if (!r_q[34]) begin
					x_q <= x_q - (y_q >>> i_q);
					y_q <= y_q + (x_q >>> i_q);
					r_q <= r_q - atn;
				end else begin
					x_q <= x_q + (y_q >>> i_q);
					y_q <= y_q - (x_q >>> i_q);
					r_q <= r_q + atn;
				end
				i_q <= i_q + IW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		res_q.cos_v = flip_q ? -x_q : x_q;
		res_q.sin_v = flip_q ? -y_q : y_q;
	end
endmodule
`default_nettype wire

// File: test/tb_euler_fly_camera_pose_update.sv
`timescale 1ns / 1ps
module tb_euler_fly_camera_pose_update;

	typedef struct packed {
		logic signed [31:0] px, py, pz, pitch, yaw;
		logic signed [17:0] fx, fy, fz, ux, uy, uz;
	} pose_t;

	typedef struct {
		efc_pkg::cmd_t      cmd;
		logic signed [31:0] dp, dy;
		efc_pkg::axis_t     axis;
		logic               positive;
		bit                 typed;
		pose_t              want;
	} stim_t;

	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint PI     = 64'sd3373259426;
	localparam longint HPI    = 64'sd1686629713;
	localparam longint GAIN   = 64'sd652032874;
	localparam int     N_RAND = 630;
	localparam longint LIMIT  = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	efc_in_if  in_ch();
	efc_out_if out_ch();
	efc_cfg_if cfg_ch();

	euler_fly_camera_pose_update u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// camera state mirror
	longint m_move, m_rot, m_sx, m_sy, m_sz, m_spitch, m_syaw;
	longint m_pos[3];
	longint m_pitch, m_yaw;
	longint m_fwd[3];
	longint m_up[3];

	pose_t pending_poses[$];
	int    n_err = 0;
	longint cycles = 0;
	int    idle_pct = 27;

	function automatic longint fsh(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rsh(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic longint arctan(int i);
		longint t[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768};
		return t[i];
	endfunction

	task automatic cordic(input longint ang, output longint c, output longint s);
		longint r, x, y, nx;
		bit flip;
		r = (ang * 16384) % TWO_PI;
		x = GAIN;
		y = 0;
		flip = 0;
		if (r < 0) r += TWO_PI;
		if (r > PI) r -= TWO_PI;
		if (r > HPI) begin
			r -= PI;
			flip = 1;
		end else if (r < -HPI) begin
			r += PI;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (r >= 0) begin
				nx = x - fsh(y, i);
				y = y + fsh(x, i);
				r -= arctan(i);
			end else begin
				nx = x + fsh(y, i);
				y = y - fsh(x, i);
				r += arctan(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic aim_vectors();
		longint cp, sp, cy, sy, fx, fy, fz;
		cordic(m_pitch, cp, sp);
		cordic(m_yaw, cy, sy);
		fx = unit_clamp(rsh(cy * cp, 44));
		fy = unit_clamp(rsh(sp, 14));
		fz = unit_clamp(rsh(sy * cp, 44));
		m_fwd = '{fx, fy, fz};
		m_up[0] = unit_clamp(rsh(fx * fy, 16));
		m_up[1] = unit_clamp(rsh(-(fx * fx + fz * fz), 16));
		m_up[2] = unit_clamp(rsh(fy * fz, 16));
	endtask

	task automatic camera_reset();
		m_move = 65536;
		m_rot = 65536;
		m_sx = 0;
		m_sy = 0;
		m_sz = 0;
		m_spitch = 0;
		m_syaw = 0;
		m_pos = '{0, 0, 0};
		m_pitch = 0;
		m_yaw = 0;
		m_fwd = '{65536, 0, 0};
		m_up = '{0, -65536, 0};
	endtask

	task automatic camera_step(input stim_t s, output pose_t p);
		longint pu, yu, d;
		longint dir[3];
		bit changed;
		case (s.cmd)
			efc_pkg::CMD_ROTATE: begin
				pu = sat(rsh(longint'(s.dp) * m_rot, 16));
				yu = sat(rsh(longint'(s.dy) * m_rot, 16));
				changed = 0;
				if ((pu < 0 ? -pu : pu) > 6) begin
					m_pitch = sat(m_pitch + pu);
					changed = 1;
				end
				if ((yu < 0 ? -yu : yu) > 6) begin
					m_yaw = sat(m_yaw + yu);
					changed = 1;
				end
				if (changed) aim_vectors();
			end
			efc_pkg::CMD_TRANSLATE: begin
				if (s.axis != efc_pkg::AXIS_NONE) begin
					case (s.axis)
						efc_pkg::AXIS_FWD: dir = m_fwd;
						efc_pkg::AXIS_RIGHT: dir = '{-m_fwd[2], 0, m_fwd[0]};
						default: dir = m_up;
					endcase
					for (int i = 0; i < 3; i++) begin
						d = rsh(m_move * dir[i], 16);
						m_pos[i] = sat(m_pos[i] + (s.positive ? d : -d));
					end
				end
			end
			efc_pkg::CMD_RESTART: begin
				m_pos = '{m_sx, m_sy, m_sz};
				m_pitch = m_spitch;
				m_yaw = m_syaw;
				aim_vectors();
			end
			default: ;
		endcase
		p.px = m_pos[0];
		p.py = m_pos[1];
		p.pz = m_pos[2];
		p.pitch = m_pitch;
		p.yaw = m_yaw;
		p.fx = m_fwd[0];
		p.fy = m_fwd[1];
		p.fz = m_fwd[2];
		p.ux = m_up[0];
		p.uy = m_up[1];
		p.uz = m_up[2];
	endtask

	task automatic report(input string what, input longint got, input longint want);
		n_err++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// drive idle values
	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = efc_pkg::CMD_NONE;
		in_ch.pitch_delta = '0;
		in_ch.yaw_delta = '0;
		in_ch.axis = efc_pkg::AXIS_NONE;
		in_ch.positive = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = efc_pkg::REG_UNUSED;
		cfg_ch.data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_euler_fly_camera_pose_update failed");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		pose_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_poses.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				w = pending_poses.pop_front();
				if (out_ch.pos_x !== w.px) report("pos_x", out_ch.pos_x, w.px);
				if (out_ch.pos_y !== w.py) report("pos_y", out_ch.pos_y, w.py);
				if (out_ch.pos_z !== w.pz) report("pos_z", out_ch.pos_z, w.pz);
				if (out_ch.pitch_now !== w.pitch) report("pitch_now", out_ch.pitch_now, w.pitch);
				if (out_ch.yaw_now !== w.yaw) report("yaw_now", out_ch.yaw_now, w.yaw);
				if (out_ch.fwd_x !== w.fx) report("fwd_x", out_ch.fwd_x, w.fx);
				if (out_ch.fwd_y !== w.fy) report("fwd_y", out_ch.fwd_y, w.fy);
				if (out_ch.fwd_z !== w.fz) report("fwd_z", out_ch.fwd_z, w.fz);
				if (out_ch.up_x !== w.ux) report("up_x", out_ch.up_x, w.ux);
				if (out_ch.up_y !== w.uy) report("up_y", out_ch.up_y, w.uy);
				if (out_ch.up_z !== w.uz) report("up_z", out_ch.up_z, w.uz);
			end
		end
		if (arst_n) out_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic write_reg(input efc_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			efc_pkg::REG_MOVE_SPEED: m_move = val[30:0];
			efc_pkg::REG_ROTATE_SPEED: m_rot = val[30:0];
			efc_pkg::REG_START_X: m_sx = longint'(signed'(val));
			efc_pkg::REG_START_Y: m_sy = longint'(signed'(val));
			efc_pkg::REG_START_Z: m_sz = longint'(signed'(val));
			efc_pkg::REG_START_PITCH: m_spitch = longint'(signed'(val));
			efc_pkg::REG_START_YAW: m_syaw = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send(input stim_t s);
		pose_t p;
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.cmd <= s.cmd;
		in_ch.pitch_delta <= s.dp;
		in_ch.yaw_delta <= s.dy;
		in_ch.axis <= s.axis;
		in_ch.positive <= s.positive;
		do @(posedge clk); while (!in_ch.ready);
		camera_step(s, p);
		if (s.typed && p != s.want) report("directed row", 0, 1);
		pending_poses.push_back(p);
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic stim_t row(efc_pkg::cmd_t c, longint dp, longint dy,
		efc_pkg::axis_t a, bit pos);
		stim_t s;
		s.cmd = c;
		s.dp = dp;
		s.dy = dy;
		s.axis = a;
		s.positive = pos;
		s.typed = 0;
		return s;
	endfunction

	function automatic stim_t rand_item(bit formed);
		stim_t s;
		int k;
		s = row(efc_pkg::cmd_t'($urandom_range(3)), $urandom, $urandom,
			efc_pkg::axis_t'($urandom_range(3)), $urandom_range(1));
		if (formed) begin
			k = $urandom_range(9);
			s.cmd = k < 4 ? efc_pkg::CMD_ROTATE :
				(k < 9 ? efc_pkg::CMD_TRANSLATE : efc_pkg::CMD_RESTART);
			s.axis = efc_pkg::axis_t'($urandom_range(2));
			if ($urandom_range(3) != 0) begin
				s.dp = $signed($urandom_range(40000)) - 20000;
				s.dy = $signed($urandom_range(40000)) - 20000;
			end
			if ($urandom_range(9) == 0) s.dp = $signed($urandom_range(12)) - 6;
		end
		return s;
	endfunction

	stim_t directed[$];

	initial begin
		stim_t s;
		camera_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// after reset, untouched pose
		s = row(efc_pkg::CMD_NONE, 32'h7fffffff, 1, efc_pkg::AXIS_FWD, 1);
		s.typed = 1;
		s.want = '{0, 0, 0, 0, 0, 65536, 0, 0, 0, -65536, 0};
		directed.push_back(s);
		s = row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_FWD, 1);
		s.typed = 1;
		s.want = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, -65536, 0};
		directed.push_back(s);
		s = row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_NONE, 1);
		s.typed = 1;
		s.want = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, -65536, 0};
		directed.push_back(s);
		// dead zone: scaled delta of 6 ignored
		s = row(efc_pkg::CMD_ROTATE, 6, -6, efc_pkg::AXIS_FWD, 0);
		s.typed = 1;
		s.want = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, -65536, 0};
		directed.push_back(s);
		directed.push_back(row(efc_pkg::CMD_ROTATE, 7, 0, efc_pkg::AXIS_FWD, 0));
		directed.push_back(row(efc_pkg::CMD_ROTATE, 0, -7, efc_pkg::AXIS_FWD, 0));
		directed.push_back(row(efc_pkg::CMD_ROTATE, 32'sh7fffffff, 32'sh80000000,
			efc_pkg::AXIS_FWD, 0));
		directed.push_back(row(efc_pkg::CMD_ROTATE, 32'sh7fffffff, 32'sh80000000,
			efc_pkg::AXIS_FWD, 0));
		directed.push_back(row(efc_pkg::CMD_ROTATE, 102944, -51472, efc_pkg::AXIS_UP, 1));
		directed.push_back(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_FWD, 0));
		directed.push_back(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_RIGHT, 1));
		directed.push_back(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_RIGHT, 0));
		directed.push_back(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_UP, 1));
		directed.push_back(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_UP, 0));
		directed.push_back(row(efc_pkg::CMD_RESTART, 0, 0, efc_pkg::AXIS_FWD, 0));
		foreach (directed[i]) send(directed[i]);
		drain();

		// extremes of the registers, START_Z apart
		write_reg(efc_pkg::REG_MOVE_SPEED, 32'hffffffff);
		write_reg(efc_pkg::REG_ROTATE_SPEED, 32'h7fffffff);
		write_reg(efc_pkg::REG_START_X, 32'h7fffffff);
		write_reg(efc_pkg::REG_START_Y, 32'h80000000);
		write_reg(efc_pkg::REG_START_Z, 32'h12345678);
		write_reg(efc_pkg::REG_START_PITCH, 32'h80000000);
		write_reg(efc_pkg::REG_START_YAW, 32'h7fffffff);
		send(row(efc_pkg::CMD_RESTART, 0, 0, efc_pkg::AXIS_FWD, 0));
		for (int i = 0; i < 8; i++) send(rand_item(1));
		send(row(efc_pkg::CMD_ROTATE, 1, -1, efc_pkg::AXIS_FWD, 0));
		drain();

		write_reg(efc_pkg::REG_MOVE_SPEED, 0);
		write_reg(efc_pkg::REG_ROTATE_SPEED, 0);
		send(row(efc_pkg::CMD_TRANSLATE, 0, 0, efc_pkg::AXIS_FWD, 1));
		send(row(efc_pkg::CMD_ROTATE, 32'sh7fffffff, 32'sh80000000, efc_pkg::AXIS_FWD, 1));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(efc_pkg::REG_MOVE_SPEED, $urandom_range(1 << 20));
			write_reg(efc_pkg::REG_ROTATE_SPEED, $urandom_range(1 << 17));
			write_reg(efc_pkg::REG_START_X, $urandom);
			write_reg(efc_pkg::REG_START_Y, $urandom);
			write_reg(efc_pkg::REG_START_Z, $urandom);
			write_reg(efc_pkg::REG_START_PITCH, $urandom);
			write_reg(efc_pkg::REG_START_YAW, ph == 0 ? 32'h0 : $urandom);
			idle_pct = (ph == 2) ? 0 : 27;
			for (int i = 0; i < N_RAND / 5; i++) begin
				send(rand_item($urandom_range(9) < 8));
				if (i == 60) drain();
			end
			drain();
		end
		idle_pct = 27;
		if (n_err == 0) begin
			$display("tb_euler_fly_camera_pose_update passed");
		end else begin
			$display("tb_euler_fly_camera_pose_update failed");
		end
		$finish;
	end

endmodule
